[rtl/hbos_pkg.sv]
package hbos_pkg;

  // Field widths
  localparam int KEY_W   = 31;
  localparam int OPND_W  = 20;  // mult_a, add_b, residue
  localparam int NPLAN_W = 10;
  localparam int MOD_W   = NPLAN_W + 1;  // 2n
  localparam int IDX_W   = MOD_W;        // remainder below 2n
  localparam int LEN_W   = 10;
  localparam int CONF_W  = 16;
  localparam int BKT_OUT_W = 10;

  // Count storage
  localparam int BUCKETS = 1024;
  localparam int BKT_W   = $clog2(BUCKETS);

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] CFG_MULT_A       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ADD_B        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEYS_PLANNED = 2'd2;

  localparam logic [OPND_W-1:0]  MULT_A_RST       = 20'd1;
  localparam logic [OPND_W-1:0]  ADD_B_RST        = 20'd0;
  localparam logic [NPLAN_W-1:0] KEYS_PLANNED_RST = 10'd512;

  // Hash constants
  localparam logic [OPND_W-1:0] HASH_PRIME = 20'd999149;
  localparam logic [LEN_W-1:0]  LEN_MAX    = '1;
  localparam logic [CONF_W-1:0] CONF_MAX   = '1;

  // Residue of the prime reduction, handed to the bucket reduction
  typedef struct packed {
    logic              valid;
    logic [OPND_W-1:0] residue;
  } hbos_resd_t;

  // Bucket index, handed to the count store
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] idx;
  } hbos_idx_t;

  // One finished result
  typedef struct packed {
    logic [BKT_OUT_W-1:0] bucket;
    logic [LEN_W-1:0]     chain_length;
    logic [LEN_W-1:0]     max_length;
    logic [CONF_W-1:0]    conflicts;
  } hbos_res_t;

endpackage

[rtl/hbos_modmul.sv]
// Bit-serial (a * key + b) mod prime, key bits MSB first, Horner form.
module hbos_modmul
  import hbos_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [KEY_W-1:0]  key,
  input  logic [OPND_W-1:0] mult_a,
  input  logic [OPND_W-1:0] add_b,
  output hbos_resd_t        resd
);

  localparam int ACC_W = OPND_W + 2;
  localparam int CNT_W = $clog2(KEY_W + 1);
  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(KEY_W);
  localparam logic [ACC_W-1:0] P_X  = ACC_W'(HASH_PRIME);
  localparam logic [ACC_W-1:0] P2_X = ACC_W'({HASH_PRIME, 1'b0});

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [KEY_W-1:0]  key_sr_r, key_sr_nxt;
  logic [OPND_W-1:0] acc_r, acc_nxt;
  logic [OPND_W-1:0] a_r, a_nxt;
  logic [OPND_W-1:0] b_r, b_nxt;
  logic [ACC_W-1:0]  t;

  always_comb begin
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    cnt_nxt    = cnt_r;
    key_sr_nxt = key_sr_r;
    acc_nxt    = acc_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    t          = '0;
    if (start) begin
      busy_nxt   = 1'b1;
      cnt_nxt    = '0;
      key_sr_nxt = key;
      acc_nxt    = '0;
      // operands are below twice the prime: one subtract reduces them
      a_nxt      = (mult_a >= HASH_PRIME) ? mult_a - HASH_PRIME : mult_a;
      b_nxt      = (add_b >= HASH_PRIME) ? add_b - HASH_PRIME : add_b;
    end else if (busy_r) begin
      if (cnt_r != LAST_BIT) begin
        // double, add a on a one bit, fold back below the prime
        t = {1'b0, acc_r, 1'b0} + (key_sr_r[KEY_W-1] ? ACC_W'(a_r) : '0);
        if (t >= P2_X) begin
          t = t - P2_X;
        end else if (t >= P_X) begin
          t = t - P_X;
        end
        acc_nxt    = t[OPND_W-1:0];
        key_sr_nxt = {key_sr_r[KEY_W-2:0], 1'b0};
        cnt_nxt    = cnt_r + 1'b1;
      end else begin
        t = ACC_W'(acc_r) + ACC_W'(b_r);
        if (t >= P_X) begin
          t = t - P_X;
        end
        acc_nxt  = t[OPND_W-1:0];
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    key_sr_r <= key_sr_nxt;
    acc_r    <= acc_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
  end

  assign resd.valid   = done_r;
  assign resd.residue = acc_r;

endmodule

[rtl/hbos_bktmod.sv]
// Restoring remainder of the residue by 2n, one residue bit per cycle.
module hbos_bktmod
  import hbos_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  hbos_resd_t         resd,
  input  logic [NPLAN_W-1:0] keys_planned,
  output hbos_idx_t          bidx
);

  localparam int CNT_W = $clog2(OPND_W);
  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(OPND_W - 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [OPND_W-1:0] sr_r, sr_nxt;
  logic [IDX_W-1:0]  rem_r, rem_nxt;
  logic [MOD_W-1:0]  modulus;
  logic [IDX_W:0]    t;

  assign modulus = {keys_planned, 1'b0};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    sr_nxt   = sr_r;
    rem_nxt  = rem_r;
    t        = {rem_r, sr_r[OPND_W-1]};
    if (resd.valid) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      sr_nxt   = resd.residue;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (t >= (IDX_W + 1)'(modulus)) begin
        rem_nxt = IDX_W'(t - (IDX_W + 1)'(modulus));
      end else begin
        rem_nxt = t[IDX_W-1:0];
      end
      sr_nxt  = {sr_r[OPND_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_BIT) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    sr_r  <= sr_nxt;
    rem_r <= rem_nxt;
  end

  // zero planned keys: the remainder is not used, bucket zero
  assign bidx.valid = done_r;
  assign bidx.idx   = (keys_planned == '0) ? '0 : rem_r;

endmodule

[rtl/hbos_counts.sv]
// Per-bucket occupancy counts, longest chain and conflict total.
module hbos_counts
  import hbos_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  hbos_idx_t bidx,
  input  logic      take,
  output logic      clearing,
  output logic      res_valid,
  output hbos_res_t res
);

  localparam int WIDE_W = (IDX_W > BKT_W) ? IDX_W : BKT_W;
  localparam int OWID_W = (BKT_W > BKT_OUT_W) ? BKT_W : BKT_OUT_W;
  localparam logic [BKT_W-1:0] LAST_ADDR = BKT_W'(BUCKETS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_UPD  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [LEN_W-1:0] mem [BUCKETS];

  logic [1:0]        state_r, state_nxt;
  logic              clr_r, clr_nxt;
  logic [BKT_W-1:0]  clr_addr_r, clr_addr_nxt;
  logic [BKT_W-1:0]  addr_r, addr_nxt;
  logic [LEN_W-1:0]  rd_r;
  logic [LEN_W-1:0]  longest_r, longest_nxt;
  logic [CONF_W-1:0] conf_r, conf_nxt;
  hbos_res_t         res_r, res_nxt;
  logic [WIDE_W-1:0] idx_wide;
  logic [BKT_W-1:0]  rd_addr;
  logic [OWID_W-1:0] addr_wide;
  logic [LEN_W-1:0]  cnt_new;
  logic              we;
  logic [BKT_W-1:0]  wr_addr;
  logic [LEN_W-1:0]  wr_data;

  // wrap the bucket into storage
  assign idx_wide  = WIDE_W'(bidx.idx);
  assign rd_addr   = idx_wide[BKT_W-1:0];
  assign addr_wide = OWID_W'(addr_r);
  assign cnt_new   = (rd_r == LEN_MAX) ? rd_r : rd_r + 1'b1;

  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    clr_addr_nxt = clr_addr_r;
    addr_nxt     = addr_r;
    longest_nxt  = longest_r;
    conf_nxt     = conf_r;
    res_nxt      = res_r;
    we           = 1'b0;
    wr_addr      = addr_r;
    wr_data      = cnt_new;
    if (clr_r) begin
      we           = 1'b1;
      wr_addr      = clr_addr_r;
      wr_data      = '0;
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == LAST_ADDR) begin
        clr_nxt = 1'b0;
      end
    end
    case (state_r)
      ST_IDLE: begin
        if (bidx.valid) begin
          addr_nxt  = rd_addr;
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        we = 1'b1;
        if (rd_r != '0 && conf_r != CONF_MAX) begin
          conf_nxt = conf_r + 1'b1;
        end
        if (cnt_new > longest_r) begin
          longest_nxt = cnt_new;
        end
        res_nxt.bucket       = addr_wide[BKT_OUT_W-1:0];
        res_nxt.chain_length = cnt_new;
        res_nxt.max_length   = (cnt_new > longest_r) ? cnt_new : longest_r;
        res_nxt.conflicts    = conf_nxt;
        state_nxt            = ST_HOLD;
      end
      ST_HOLD: begin
        if (take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
      longest_r  <= '0;
      conf_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_r      <= clr_nxt;
      clr_addr_r <= clr_addr_nxt;
      longest_r  <= longest_nxt;
      conf_r     <= conf_nxt;
    end
    addr_r <= addr_nxt;
    res_r  <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_r <= mem[rd_addr];
  end

  assign clearing  = clr_r;
  assign res_valid = (state_r == ST_HOLD);
  assign res       = res_r;

endmodule

[rtl/hash_bucket_occupancy_stats.sv]
// Channel  Direction  Handshake          Beat payload
// in       input      in_valid/in_stall  in_key (31 b)
// out      output     out_valid/out_stall out_bucket, out_chain_length, out_max_length,
//                                         out_conflicts
// cfg      input      cfg_we             cfg_addr, cfg_wdata (write only)
//
// From accept to a loaded output register, one key passes through a bit-serial modular
// multiply over the key bits, then a bit-serial remainder by 2n over the residue bits,
// then a read-modify-write of the count RAM.
// One key is in flight at a time; the next key is taken while a result waits in
// the output register.
// After reset the count RAM is cleared one entry per cycle, all BUCKETS (1024) entries;
// in_stall stays high meanwhile. Configuration writes are taken at any time.
// out_stall holds the output register and, once the count stage is full, the input.
module hash_bucket_occupancy_stats
  import hbos_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // key input
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [KEY_W-1:0]      in_key,
  // results
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [BKT_OUT_W-1:0]  out_bucket,
  output logic [LEN_W-1:0]      out_chain_length,
  output logic [LEN_W-1:0]      out_max_length,
  output logic [CONF_W-1:0]     out_conflicts,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [OPND_W-1:0]  mult_a_r, mult_a_nxt;
  logic [OPND_W-1:0]  add_b_r, add_b_nxt;
  logic [NPLAN_W-1:0] keys_planned_r, keys_planned_nxt;
  logic               busy_r, busy_nxt;
  logic               out_valid_r, out_valid_nxt;
  hbos_res_t          out_r, out_nxt;

  logic       in_accept;
  logic       take;
  logic       clearing;
  logic       res_valid;
  hbos_res_t  res;
  hbos_resd_t resd;
  hbos_idx_t  bidx;

  // hold off keys while one is in flight or the RAM is being cleared
  assign in_stall  = busy_r | clearing;
  assign in_accept = in_valid & ~in_stall;

  // move a finished result into an empty or draining output register
  assign take = res_valid & (~out_valid_r | ~out_stall);

  always_comb begin
    mult_a_nxt       = mult_a_r;
    add_b_nxt        = add_b_r;
    keys_planned_nxt = keys_planned_r;
    if (cfg_we) begin
      case (cfg_addr)
        CFG_MULT_A:       mult_a_nxt       = cfg_wdata[OPND_W-1:0];
        CFG_ADD_B:        add_b_nxt        = cfg_wdata[OPND_W-1:0];
        CFG_KEYS_PLANNED: keys_planned_nxt = cfg_wdata[NPLAN_W-1:0];
        default: begin
          // drop writes past the last register
        end
      endcase
    end
  end

  always_comb begin
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (take) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
      busy_nxt      = 1'b0;
    end
    if (in_accept) begin
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_a_r       <= MULT_A_RST;
      add_b_r        <= ADD_B_RST;
      keys_planned_r <= KEYS_PLANNED_RST;
      busy_r         <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      mult_a_r       <= mult_a_nxt;
      add_b_r        <= add_b_nxt;
      keys_planned_r <= keys_planned_nxt;
      busy_r         <= busy_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  hbos_modmul u_modmul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_accept),
    .key    (in_key),
    .mult_a (mult_a_r),
    .add_b  (add_b_r),
    .resd   (resd)
  );

  hbos_bktmod u_bktmod (
    .clk          (clk),
    .rst_n        (rst_n),
    .resd         (resd),
    .keys_planned (keys_planned_r),
    .bidx         (bidx)
  );

  hbos_counts u_counts (
    .clk       (clk),
    .rst_n     (rst_n),
    .bidx      (bidx),
    .take      (take),
    .clearing  (clearing),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_valid        = out_valid_r;
  assign out_bucket       = out_r.bucket;
  assign out_chain_length = out_r.chain_length;
  assign out_max_length   = out_r.max_length;
  assign out_conflicts    = out_r.conflicts;

endmodule

[rtl/hbos_checker.sv]
module hbos_checker
  import hbos_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [BKT_OUT_W-1:0] out_bucket,
  input logic [LEN_W-1:0]     out_chain_length,
  input logic [LEN_W-1:0]     out_max_length,
  input logic [CONF_W-1:0]    out_conflicts
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_bucket) && $stable(out_chain_length)
      && $stable(out_max_length) && $stable(out_conflicts))
    else $error("out payload changed while stalled");

  a_chain_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_chain_length != '0)
    else $error("chain length zero after insertion");

  a_max_covers_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_max_length >= out_chain_length)
    else $error("longest chain below current chain");

endmodule

bind hash_bucket_occupancy_stats hbos_checker u_hbos_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_bucket       (out_bucket),
  .out_chain_length (out_chain_length),
  .out_max_length   (out_max_length),
  .out_conflicts    (out_conflicts)
);
